[hw/rtl/interval_set_table_top_defines.svh]
// ----------------------------------------------------------------------------
// interval_set_table_top_defines
// assertion helpers for the interval set table
// ----------------------------------------------------------------------------
`ifndef INTERVAL_SET_TABLE_TOP_DEFINES_SVH
`define INTERVAL_SET_TABLE_TOP_DEFINES_SVH
`define IST_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define IST_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

[hw/rtl/ist_pkg.sv]
// ----------------------------------------------------------------------------
// ist_pkg
// types and codes shared by the interval set table modules
// ----------------------------------------------------------------------------
package ist_pkg;
    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_DEL    = 2'd1;
    localparam logic [1:0] OP_COUNT  = 2'd2;
    localparam logic [1:0] OP_LOOKUP = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_RD, S_WAIT, S_EVAL, S_RDLAST, S_WAITLAST, S_MOVE,
        S_APPEND, S_DONE
    } t_state;

    typedef struct packed {
        logic load;     // latch input beat
        logic rd_cur;   // read slot at index
        logic rd_last;  // read last slot
        logic eval;     // evaluate entry at index
        logic move;     // move last slot into index
        logic append;   // write union entry, new span or split piece
        logic step;     // index down
        logic finish;   // present result
    } t_cmd;

    typedef struct packed {
        logic invalid;
        logic idx_zero;
        logic empty_start;
        logic hit;
        logic need_move;
        logic need_append;
    } t_sts;
endpackage

[hw/rtl/ist_ram.sv]
// ----------------------------------------------------------------------------
// ist_ram
// single port ram with registered read
// ----------------------------------------------------------------------------
module ist_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

[hw/rtl/ist_ctrl.sv]
// ----------------------------------------------------------------------------
// ist_ctrl
// sequencer for the table scan
// ----------------------------------------------------------------------------
module ist_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_out_taken,
    input  logic           i_out_busy,
    input  ist_pkg::t_sts  i_sts,
    output logic           o_in_ready,
    output ist_pkg::t_cmd  o_cmd
);
    ist_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ist_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ist_pkg::S_IDLE:     if (i_in_valid && !i_out_busy) n_state = ist_pkg::S_CHECK;
            ist_pkg::S_CHECK: begin
                if (i_sts.invalid) n_state = ist_pkg::S_DONE;
                else if (i_sts.empty_start) n_state = ist_pkg::S_APPEND;
                else n_state = ist_pkg::S_RD;
            end
            ist_pkg::S_RD:       n_state = ist_pkg::S_WAIT;
            ist_pkg::S_WAIT:     n_state = ist_pkg::S_EVAL;
            ist_pkg::S_EVAL: begin
                if (i_sts.need_move) n_state = ist_pkg::S_RDLAST;
                else if (i_sts.idx_zero) n_state = ist_pkg::S_APPEND;
                else n_state = ist_pkg::S_RD;
            end
            ist_pkg::S_RDLAST:   n_state = ist_pkg::S_WAITLAST;
            ist_pkg::S_WAITLAST: n_state = ist_pkg::S_MOVE;
            ist_pkg::S_MOVE: begin
                if (i_sts.idx_zero) n_state = ist_pkg::S_APPEND;
                else n_state = ist_pkg::S_RD;
            end
            ist_pkg::S_APPEND:   n_state = ist_pkg::S_DONE;
            ist_pkg::S_DONE:     if (!i_out_busy || i_out_taken) n_state = ist_pkg::S_IDLE;
            default:             n_state = ist_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ist_pkg::S_IDLE: begin
                o_in_ready = !i_out_busy;
                o_cmd.load = i_in_valid && !i_out_busy;
            end
            ist_pkg::S_RD:       o_cmd.rd_cur = 1'b1;
            ist_pkg::S_EVAL: begin
                o_cmd.eval = 1'b1;
                o_cmd.step = !i_sts.need_move && !i_sts.idx_zero;
            end
            ist_pkg::S_RDLAST:   o_cmd.rd_last = 1'b1;
            ist_pkg::S_WAITLAST: o_cmd.rd_last = 1'b1;
            ist_pkg::S_MOVE: begin
                o_cmd.move = 1'b1;
                o_cmd.step = !i_sts.idx_zero;
            end
            ist_pkg::S_APPEND:   o_cmd.append = i_sts.need_append;
            ist_pkg::S_DONE:     o_cmd.finish = !i_out_busy || i_out_taken;
            default:             o_cmd = '0;
        endcase
    end
endmodule

[hw/rtl/ist_dp.sv]
// ----------------------------------------------------------------------------
// ist_dp
// table storage, span registers and result fields
// ----------------------------------------------------------------------------
`include "interval_set_table_top_defines.svh"
module ist_dp #(
    parameter int CAPACITY = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ist_pkg::t_cmd  i_cmd,
    input  logic [1:0]     i_op,
    input  logic [63:0]    i_a,
    input  logic [63:0]    i_b,
    input  logic [63:0]    i_addr,
    input  logic           i_out_taken,
    output ist_pkg::t_sts  o_sts,
    output logic           o_out_busy,
    output logic [1:0]     o_status,
    output logic [6:0]     o_hit_count,
    output logic           o_found,
    output logic [63:0]    o_found_start,
    output logic [63:0]    o_found_end
);
    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic [1:0]    r_op;
    logic [63:0]   r_a, r_b, r_addr, r_fs, r_fe;
    logic [CW-1:0] r_used, r_k, r_tgt;
    logic          r_have, r_full, r_found, r_out_busy;
    logic [6:0]    r_hc;
    logic [1:0]    r_status;
    logic [63:0]   r_split_b, r_split_e;
    logic          r_split;
    logic [63:0]   r_ts, r_te;

    logic          we;
    logic [IW-1:0] addr;
    logic [127:0]  wdata, rdata;
    logic [63:0]   s, e;
    logic [CW-1:0] idx, last;

    ist_ram #(.WIDTH(128), .DEPTH(CAPACITY)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_addr(addr), .i_wdata(wdata), .o_rdata(rdata)
    );

    assign s = rdata[63:0];
    assign e = rdata[127:64];
    assign idx = r_k - CW'(1);
    assign last = r_used - CW'(1);

    logic hit, lk_hit;
    assign hit = (r_a < e) && (r_b > s);
    assign lk_hit = (r_addr >= s) && (r_addr < e);

    // evaluation: decide write and whether a removal is needed
    logic          rm;
    logic [63:0]   ns, ne;
    always_comb begin
        rm = 1'b0;
        ns = s;
        ne = e;
        case (r_op)
            ist_pkg::OP_ADD: begin
                if (hit && r_have) rm = 1'b1;
                ns = (r_a < s) ? r_a : s;
                ne = (r_b > e) ? r_b : e;
            end
            ist_pkg::OP_DEL: begin
                if (hit) begin
                    if (r_a <= s && r_b >= e) rm = 1'b1;
                    else if (r_a <= s) ns = r_b;
                    else ne = r_a;
                end
            end
            default: rm = 1'b0;
        endcase
    end

    logic do_lookup_scan;
    assign do_lookup_scan = (r_op == ist_pkg::OP_LOOKUP) && !r_found;

    assign o_sts.invalid = (r_op != ist_pkg::OP_LOOKUP) && (r_a >= r_b);
    assign o_sts.idx_zero = (r_k == CW'(1));
    assign o_sts.empty_start = (r_used == '0);
    assign o_sts.hit = hit;
    assign o_sts.need_move = rm && (idx != last);
    assign o_sts.need_append = (r_op == ist_pkg::OP_ADD) || r_split;

    // ram port: a pending split piece is written into the last slot by the read step,
    // which then reads that slot rather than the one at idx, eval writes entry, move writes last into idx,
    // append writes the union entry or the new span or the last split piece
    always_comb begin
        we = 1'b0;
        addr = idx[IW-1:0];
        wdata = {ne, ns};
        if (i_cmd.rd_last) begin
            addr = r_used[IW-1:0];
        end else if (i_cmd.rd_cur) begin
            if (r_split) begin
                we = 1'b1;
                addr = last[IW-1:0];
                wdata = {r_split_e, r_split_b};
            end
        end else if (i_cmd.eval) begin
            we = !rm && ((r_op == ist_pkg::OP_ADD && hit && !r_have) ||
                         (r_op == ist_pkg::OP_DEL && hit));
            if (r_op == ist_pkg::OP_ADD && hit && !r_have) begin
                wdata = {(r_b > e) ? r_b : e, (r_a < s) ? r_a : s};
            end
        end else if (i_cmd.move) begin
            we = 1'b1;
            wdata = rdata;
        end else if (i_cmd.append) begin
            if (r_op == ist_pkg::OP_ADD && r_have) begin
                we = 1'b1;
                addr = r_tgt[IW-1:0];
                wdata = {r_te, r_ts};
            end else if (r_op == ist_pkg::OP_ADD) begin
                we = !r_full;
                addr = r_used[IW-1:0];
                wdata = {r_b, r_a};
            end else begin
                we = 1'b1;
                addr = last[IW-1:0];
                wdata = {r_split_e, r_split_b};
            end
        end
    end

    // add merges into the union entry held at r_tgt: the union is kept in
    // r_ts/r_te and written back to the target slot once the scan ends
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_out_busy <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_op <= i_op;
                r_a <= i_a;
                r_b <= i_b;
                r_addr <= i_addr;
                r_k <= r_used;
                r_have <= 1'b0;
                r_hc <= '0;
                r_found <= 1'b0;
                r_fs <= '0;
                r_fe <= '0;
                r_status <= ist_pkg::ST_OK;
                r_split <= 1'b0;
                r_full <= (r_used == CW'(CAPACITY));
                r_tgt <= '0;
            end
            if (i_cmd.rd_cur) r_split <= 1'b0;
            if (i_cmd.eval) begin
                if (r_op == ist_pkg::OP_LOOKUP && do_lookup_scan && lk_hit) begin
                    r_found <= 1'b1;
                    r_fs <= s;
                    r_fe <= e;
                end
                if ((r_op == ist_pkg::OP_DEL || r_op == ist_pkg::OP_COUNT) && hit &&
                    r_hc != 7'd127) begin
                    r_hc <= r_hc + 7'd1;
                end
                if (r_op == ist_pkg::OP_ADD && hit) begin
                    if (!r_have) begin
                        r_have <= 1'b1;
                        r_tgt <= idx;
                        r_ts <= ns;
                        r_te <= ne;
                    end else begin
                        r_a <= ns;
                        r_b <= ne;
                        r_ts <= (ns < r_ts) ? ns : r_ts;
                        r_te <= (ne > r_te) ? ne : r_te;
                    end
                end
                if (r_op == ist_pkg::OP_DEL && hit && !(r_a <= s) && !(r_b >= e)) begin
                    if (r_used == CW'(CAPACITY)) begin
                        r_status <= ist_pkg::ST_FULL;
                    end else begin
                        r_used <= r_used + CW'(1);
                        r_split <= 1'b1;
                        r_split_b <= r_b;
                        r_split_e <= e;
                    end
                end
                if (rm) begin
                    r_used <= last;
                    if (r_tgt == last && r_op == ist_pkg::OP_ADD) r_tgt <= idx;
                end
            end
            if (i_cmd.step) r_k <= idx;
            if (i_cmd.append) begin
                if (r_op == ist_pkg::OP_ADD && !r_have) begin
                    if (r_full) r_status <= ist_pkg::ST_FULL;
                    else r_used <= r_used + CW'(1);
                end
            end
            if (i_cmd.finish) begin
                r_out_busy <= 1'b1;
                if (o_sts.invalid) r_status <= ist_pkg::ST_INVALID;
            end else if (i_out_taken) begin
                r_out_busy <= 1'b0;
            end
        end
    end

    assign o_out_busy = r_out_busy;
    assign o_status = r_status;
    assign o_hit_count = r_hc;
    assign o_found = r_found;
    assign o_found_start = r_fs;
    assign o_found_end = r_fe;

    `IST_ASSERT(a_used_max, i_clk, i_rst_n, (r_used <= CW'(CAPACITY)), "used count over capacity")
    `IST_ASSERT(a_one_wr, i_clk, i_rst_n, !(i_cmd.eval && i_cmd.move), "eval and move together")
    `IST_ASSERT(a_found_lk, i_clk, i_rst_n, (r_found |-> r_op == ist_pkg::OP_LOOKUP), "found off lookup")
endmodule

[hw/rtl/interval_set_table_top.sv]
// ----------------------------------------------------------------------------
// interval_set_table_top
// bounded table of half-open address ranges with add, delete, count, lookup
//
// channel   dir  tdata fields (low bit up)
// s_axis    in   op, range_start, range_end, lookup_addr (194 -> 200 bits)
// m_axis    out  status, hit_count, found, found_start, found_end (138 -> 144)
//
// one beat is scanned over the used slots, top slot first, with each removal
// moving the last slot down, all through the single table ram port
// reset clears the fill count and the output valid; the table contents need no clearing
// a new beat is taken once the previous result has been handed on
// ----------------------------------------------------------------------------
module interval_set_table_top #(
    parameter int CAPACITY = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [199:0] s_axis_tdata,  // op, range_start, range_end, lookup_addr
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [143:0] m_axis_tdata   // status, hit_count, found, found_start, found_end
);
    ist_pkg::t_cmd cmd;
    ist_pkg::t_sts sts;
    logic          busy, taken;
    logic [1:0]    status;
    logic [6:0]    hc;
    logic          found;
    logic [63:0]   fs, fe;

    assign taken = m_axis_tvalid && m_axis_tready;

    ist_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(s_axis_tvalid),
        .i_out_taken(taken), .i_out_busy(busy), .i_sts(sts),
        .o_in_ready(s_axis_tready), .o_cmd(cmd)
    );

    ist_dp #(.CAPACITY(CAPACITY)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd),
        .i_op(s_axis_tdata[1:0]), .i_a(s_axis_tdata[65:2]),
        .i_b(s_axis_tdata[129:66]), .i_addr(s_axis_tdata[193:130]),
        .i_out_taken(taken), .o_sts(sts), .o_out_busy(busy),
        .o_status(status), .o_hit_count(hc), .o_found(found),
        .o_found_start(fs), .o_found_end(fe)
    );

    assign m_axis_tvalid = busy;
    assign m_axis_tdata = {6'd0, fe, fs, found, hc, status};
endmodule

[tb/interval_set_table_checker.sv]
// ----------------------------------------------------------------------------
// interval_set_table_checker
// watches both stream channels of the interval set table, keeps its own copy
// of the range table, predicts each result and compares it field by field
// ----------------------------------------------------------------------------
module interval_set_table_checker #(
    parameter int CAPACITY = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    input  logic         i_in_ready,
    input  logic [199:0] i_in_data,   // op, range_start, range_end, lookup_addr
    input  logic         i_out_valid,
    input  logic         i_out_ready,
    input  logic [143:0] i_out_data,  // status, hit_count, found, found_start, found_end
    output int           o_errors,
    output int           o_pending
);
    typedef struct packed {
        logic [63:0] fend;
        logic [63:0] fstart;
        logic        found;
        logic [6:0]  hits;
        logic [1:0]  status;
    } t_result;

    logic [63:0] tab_lo [CAPACITY];
    logic [63:0] tab_hi [CAPACITY];
    int          tab_used;
    t_result     pending_results [$];

    assign o_pending = pending_results.size();

    function automatic bit overlaps(int i, logic [63:0] a, logic [63:0] b);
        return a < tab_hi[i] && b > tab_lo[i];
    endfunction

    function automatic void drop_slot(int i);
        tab_lo[i] = tab_lo[tab_used - 1];
        tab_hi[i] = tab_hi[tab_used - 1];
        tab_used--;
    endfunction

    function automatic bit push_slot(logic [63:0] a, logic [63:0] b);
        if (tab_used >= CAPACITY) return 0;
        tab_lo[tab_used] = a;
        tab_hi[tab_used] = b;
        tab_used++;
        return 1;
    endfunction

    function automatic t_result apply_op(logic [199:0] d);
        t_result     r;
        logic [1:0]  op;
        logic [63:0] a, b, addr, s, e;
        bit          have;
        int          tgt, hc;
        op   = d[1:0];
        a    = d[65:2];
        b    = d[129:66];
        addr = d[193:130];
        r    = '0;
        hc   = 0;
        have = 0;
        tgt  = 0;
        if (op != ist_pkg::OP_LOOKUP && a >= b) begin
            r.status = ist_pkg::ST_INVALID;
        end else if (op == ist_pkg::OP_ADD) begin
            for (int i = tab_used - 1; i >= 0; i--) begin
                if (!overlaps(i, a, b)) continue;
                if (!have) begin
                    have = 1;
                    tgt  = i;
                end else begin
                    if (tab_lo[i] < a) a = tab_lo[i];
                    if (tab_hi[i] > b) b = tab_hi[i];
                    if (tgt == tab_used - 1) begin
                        drop_slot(i);
                        tgt = i;
                    end else begin
                        drop_slot(i);
                    end
                end
                if (a < tab_lo[tgt]) tab_lo[tgt] = a;
                if (b > tab_hi[tgt]) tab_hi[tgt] = b;
            end
            if (!have && !push_slot(a, b)) r.status = ist_pkg::ST_FULL;
        end else if (op == ist_pkg::OP_DEL) begin
            for (int i = tab_used - 1; i >= 0; i--) begin
                if (!overlaps(i, a, b)) continue;
                hc++;
                s = tab_lo[i];
                e = tab_hi[i];
                if (a <= s && b >= e) drop_slot(i);
                else if (a <= s) tab_lo[i] = b;
                else if (b >= e) tab_hi[i] = a;
                else begin
                    tab_hi[i] = a;
                    if (!push_slot(b, e)) r.status = ist_pkg::ST_FULL;
                end
            end
        end else if (op == ist_pkg::OP_COUNT) begin
            for (int i = 0; i < tab_used; i++)
                if (overlaps(i, a, b)) hc++;
        end else begin
            for (int i = tab_used - 1; i >= 0; i--) begin
                if (addr >= tab_lo[i] && addr < tab_hi[i]) begin
                    r.found  = 1'b1;
                    r.fstart = tab_lo[i];
                    r.fend   = tab_hi[i];
                    break;
                end
            end
        end
        r.hits = (hc > 127) ? 7'd127 : hc[6:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        o_errors++;
    endtask

    initial o_errors = 0;

    always @(posedge i_clk) begin
        t_result got, want;
        if (!i_rst_n) begin
            tab_used = 0;
            pending_results.delete();
        end else begin
            if (i_in_valid && i_in_ready)
                pending_results.push_back(apply_op(i_in_data));
            if (i_out_valid && i_out_ready) begin
                got = i_out_data[137:0];
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected beat", got.status, 0);
                end else begin
                    want = pending_results.pop_front();
                    if (got.status !== want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.hits !== want.hits)
                        report_mismatch("hit_count", got.hits, want.hits);
                    if (got.found !== want.found)
                        report_mismatch("found", got.found, want.found);
                    if (got.fstart !== want.fstart)
                        report_mismatch("found_start", got.fstart, want.fstart);
                    if (got.fend !== want.fend)
                        report_mismatch("found_end", got.fend, want.fend);
                end
            end
        end
    end
endmodule

[tb/tb_interval_set_table_top.sv]
// ----------------------------------------------------------------------------
// tb_interval_set_table_top
// drives directed and random range operations into the interval set table
// under several idling phases and lets the checker judge every result
// ----------------------------------------------------------------------------
module tb_interval_set_table_top;
    localparam int CAPACITY = 64;
    localparam int WATCHDOG = 20000;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [199:0] s_axis_tdata;   // op, range_start, range_end, lookup_addr
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [143:0] m_axis_tdata;   // status, hit_count, found, found_start, found_end

    int error_count;
    int pending_count;
    int idle_in_pct;
    int stall_out_pct;
    int quiet_cycles;
    int ops_sent [4];
    int item_count;

    interval_set_table_top #(.CAPACITY(CAPACITY)) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    interval_set_table_checker #(.CAPACITY(CAPACITY)) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_ready  (s_axis_tready),
        .i_in_data   (s_axis_tdata),
        .i_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_out_data  (m_axis_tdata),
        .o_errors    (error_count),
        .o_pending   (pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // receiver stalls at random
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_out_pct);
    end

    // watchdog on accepted beats
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("watchdog expired");
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic send_op(logic [1:0] op, logic [63:0] a, logic [63:0] b,
                           logic [63:0] addr);
        while ($urandom_range(99) < idle_in_pct) @(posedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, addr, b, a, op};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        s_axis_tvalid <= 1'b0;
        ops_sent[op]++;
        item_count++;
        @(posedge i_clk);
    endtask

    // small addresses so ranges collide often, sometimes full width ones
    task automatic send_random();
        logic [1:0]  op;
        logic [63:0] a, b, base;
        int          kind;
        kind = $urandom_range(99);
        op   = 2'($urandom_range(3));
        if (kind < 8) begin
            a = rand64();
            b = rand64();
        end else begin
            base = (kind < 12) ? 64'hFFFF_FFFF_FFFF_F000 : 64'd0;
            a = base + $urandom_range(4000);
            b = a + $urandom_range(300);
            if (kind < 15) b = a - $urandom_range(3);
        end
        if (op == ist_pkg::OP_ADD && $urandom_range(99) < 15) op = ist_pkg::OP_DEL;
        send_op(op, a, b, (kind < 8) ? rand64() : base + $urandom_range(4100));
    endtask

    task automatic wait_drained();
        while (pending_count != 0) @(posedge i_clk);
    endtask

    initial begin
        logic [63:0] ones;
        ones          = '1;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        idle_in_pct   = 0;
        stall_out_pct = 0;
        quiet_cycles  = 0;
        item_count    = 0;
        ops_sent      = '{default: 0};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty lookup, invalid spans, merge, trims, split, extremes
        send_op(ist_pkg::OP_LOOKUP, 0, 0, 0);
        send_op(ist_pkg::OP_ADD, 5, 5, 0);
        send_op(ist_pkg::OP_DEL, 9, 3, 0);
        send_op(ist_pkg::OP_COUNT, ones, 0, 0);
        send_op(ist_pkg::OP_ADD, 10, 20, 0);
        send_op(ist_pkg::OP_ADD, 30, 40, 0);
        send_op(ist_pkg::OP_ADD, 50, 60, 0);
        send_op(ist_pkg::OP_ADD, 20, 30, 0);
        send_op(ist_pkg::OP_ADD, 15, 55, 0);
        send_op(ist_pkg::OP_COUNT, 0, ones, 0);
        send_op(ist_pkg::OP_LOOKUP, 0, 0, 59);
        send_op(ist_pkg::OP_DEL, 0, 12, 0);
        send_op(ist_pkg::OP_DEL, 58, 100, 0);
        send_op(ist_pkg::OP_DEL, 20, 30, 0);
        send_op(ist_pkg::OP_LOOKUP, 0, 0, 30);
        send_op(ist_pkg::OP_LOOKUP, 0, 0, 20);
        send_op(ist_pkg::OP_ADD, ones - 1, ones, 0);
        send_op(ist_pkg::OP_LOOKUP, 0, 0, ones - 1);
        send_op(ist_pkg::OP_LOOKUP, 0, 0, ones);
        send_op(ist_pkg::OP_DEL, 0, ones, 0);
        send_op(ist_pkg::OP_COUNT, 0, ones, 0);
        // fill the table, overflow it, then trim one range with no free slot
        for (int i = 0; i < CAPACITY + 1; i++)
            send_op(ist_pkg::OP_ADD, 64'(4 * i), 64'(4 * i + 2), 0);
        send_op(ist_pkg::OP_DEL, 1, 2, 0);
        send_op(ist_pkg::OP_COUNT, 0, ones, 0);
        wait_drained();
        send_op(ist_pkg::OP_DEL, 0, ones, 0);

        for (int phase = 0; phase < 4; phase++) begin
            idle_in_pct   = (phase == 1) ? 64 : (phase == 3) ? 34 : 0;
            stall_out_pct = (phase == 2) ? 64 : (phase == 3) ? 34 : 0;
            for (int n = 0; n < 170; n++) send_random();
            wait_drained();
        end

        idle_in_pct   = 0;
        stall_out_pct = 0;
        wait_drained();
        repeat (400) @(posedge i_clk);
        $display("items sent %0d: add %0d, delete %0d, count %0d, lookup %0d",
                 item_count, ops_sent[0], ops_sent[1], ops_sent[2], ops_sent[3]);
        $display("covered merge, trim, split, full table and four idling phases");
        if (error_count == 0 && pending_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
